[rtl/core/qlt_pkg.sv]
// Shared types and constants for the quoted line tokenizer.
package qlt_pkg;

    localparam int QLT_QUEUE_DEPTH = 4;
    localparam int QLT_PTR_W       = $clog2(QLT_QUEUE_DEPTH);
    localparam int QLT_CNT_W       = $clog2(QLT_QUEUE_DEPTH + 1);

    localparam logic [1:0] KIND_CHAR  = 2'd0;
    localparam logic [1:0] KIND_BEGIN = 2'd1;
    localparam logic [1:0] KIND_OK    = 2'd2;
    localparam logic [1:0] KIND_ERROR = 2'd3;

    localparam logic [3:0] ERR_NONE          = 4'd0;
    localparam logic [3:0] ERR_QUOTE_IN_WORD = 4'd1;
    localparam logic [3:0] ERR_CTRL_IN_WORD  = 4'd2;
    localparam logic [3:0] ERR_UNTERM_QUOTE  = 4'd3;
    localparam logic [3:0] ERR_CTRL_IN_QUOTE = 4'd4;
    localparam logic [3:0] ERR_UNTERM_ESC    = 4'd5;
    localparam logic [3:0] ERR_BAD_HEX       = 4'd6;
    localparam logic [3:0] ERR_BAD_ESC       = 4'd7;
    localparam logic [3:0] ERR_NO_SPACE      = 4'd8;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] out_char;
        logic       quoted;
        logic [3:0] err_code;
        logic       last;
    } t_result;

    // Results produced by one accepted word: count is 0, 1 or 2.
    typedef struct packed {
        logic [1:0] count;
        t_result    res0;
        t_result    res1;
    } t_push;

endpackage

[rtl/core/qlt_scan.sv]
// Scanner state and the per-word decode that produces up to two results.
module qlt_scan
    import qlt_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_take,
    input  logic [7:0] i_in_char,
    input  logic       i_line_end,
    output t_push      o_push
);

    localparam logic [3:0] MODE_BETWEEN     = 4'd0;
    localparam logic [3:0] MODE_WORD        = 4'd1;
    localparam logic [3:0] MODE_QUOTE       = 4'd2;
    localparam logic [3:0] MODE_ESCAPE      = 4'd3;
    localparam logic [3:0] MODE_HEX_HIGH    = 4'd4;
    localparam logic [3:0] MODE_HEX_LOW     = 4'd5;
    localparam logic [3:0] MODE_AFTER_QUOTE = 4'd6;
    localparam logic [3:0] MODE_COMMENT     = 4'd7;
    localparam logic [3:0] MODE_DROP        = 4'd8;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DEL   = 8'h7f;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_BSLASH = 8'h5c;

    logic [3:0] r_mode;
    logic [3:0] n_mode;
    logic       r_seen;
    logic       n_seen;
    logic [3:0] r_nibble;
    logic [3:0] n_nibble;
    logic [3:0] r_err;
    logic [3:0] n_err;

    function automatic logic is_control(input logic [7:0] c);
        return (c < CH_SPACE && c != CH_TAB) || c == CH_DEL;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB;
    endfunction

    // Bit 4 flags a valid hex digit, bits 3:0 carry its value.
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, c[3:0]};
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

    function automatic t_result mk_char(input logic [7:0] c);
        t_result r;
        r = '0;
        r.kind     = KIND_CHAR;
        r.out_char = c;
        r.last     = 1'b1;
        return r;
    endfunction

    logic [4:0] w_hex;
    logic [7:0] w_hex_val;
    logic [3:0] w_end_err;

    always_comb begin
        w_hex     = hex_decode(i_in_char);
        w_hex_val = {r_nibble, w_hex[3:0]};
        w_end_err = r_err;
        if (r_err == ERR_NONE) begin
            if (r_mode == MODE_QUOTE) begin
                w_end_err = ERR_UNTERM_QUOTE;
            end else if (r_mode == MODE_ESCAPE) begin
                w_end_err = ERR_UNTERM_ESC;
            end else if (r_mode == MODE_HEX_HIGH || r_mode == MODE_HEX_LOW) begin
                w_end_err = ERR_BAD_HEX;
            end
        end
    end

    always_comb begin
        n_mode   = r_mode;
        n_seen   = r_seen;
        n_nibble = r_nibble;
        n_err    = r_err;
        o_push   = '0;
        if (i_line_end) begin
            o_push.count = 2'd1;
            o_push.res0.last = 1'b1;
            if (w_end_err != ERR_NONE) begin
                o_push.res0.kind     = KIND_ERROR;
                o_push.res0.err_code = w_end_err;
            end else begin
                o_push.res0.kind = KIND_OK;
            end
            n_mode   = MODE_BETWEEN;
            n_seen   = 1'b0;
            n_nibble = 4'd0;
            n_err    = ERR_NONE;
        end else begin
            unique case (r_mode)
                MODE_WORD: begin
                    if (is_space(i_in_char)) begin
                        n_mode = MODE_BETWEEN;
                    end else if (i_in_char == CH_DQUOTE) begin
                        n_err  = ERR_QUOTE_IN_WORD;
                        n_mode = MODE_DROP;
                    end else if (is_control(i_in_char)) begin
                        n_err  = ERR_CTRL_IN_WORD;
                        n_mode = MODE_DROP;
                    end else begin
                        o_push.count = 2'd1;
                        o_push.res0  = mk_char(i_in_char);
                    end
                end
                MODE_QUOTE: begin
                    if (i_in_char == CH_DQUOTE) begin
                        n_mode = MODE_AFTER_QUOTE;
                    end else if (is_control(i_in_char)) begin
                        n_err  = ERR_CTRL_IN_QUOTE;
                        n_mode = MODE_DROP;
                    end else if (i_in_char == CH_BSLASH) begin
                        n_mode = MODE_ESCAPE;
                    end else begin
                        o_push.count = 2'd1;
                        o_push.res0  = mk_char(i_in_char);
                    end
                end
                MODE_ESCAPE: begin
                    n_mode       = MODE_QUOTE;
                    o_push.count = 2'd1;
                    case (i_in_char)
                        CH_DQUOTE, CH_BSLASH: o_push.res0 = mk_char(i_in_char);
                        8'h6e: o_push.res0 = mk_char(CH_LF);
                        8'h72: o_push.res0 = mk_char(CH_CR);
                        8'h74: o_push.res0 = mk_char(CH_TAB);
                        8'h78: begin
                            o_push.count = 2'd0;
                            n_mode       = MODE_HEX_HIGH;
                        end
                        default: begin
                            o_push.count = 2'd0;
                            n_err        = ERR_BAD_ESC;
                            n_mode       = MODE_DROP;
                        end
                    endcase
                end
                MODE_HEX_HIGH: begin
                    if (w_hex[4]) begin
                        n_nibble = w_hex[3:0];
                        n_mode   = MODE_HEX_LOW;
                    end else begin
                        n_err  = ERR_BAD_HEX;
                        n_mode = MODE_DROP;
                    end
                end
                MODE_HEX_LOW: begin
                    if (w_hex[4] && is_control(w_hex_val)) begin
                        o_push.count = 2'd1;
                        o_push.res0  = mk_char(w_hex_val);
                        n_mode       = MODE_QUOTE;
                    end else begin
                        n_err  = ERR_BAD_HEX;
                        n_mode = MODE_DROP;
                    end
                end
                MODE_AFTER_QUOTE: begin
                    if (is_space(i_in_char)) begin
                        n_mode = MODE_BETWEEN;
                    end else begin
                        n_err  = ERR_NO_SPACE;
                        n_mode = MODE_DROP;
                    end
                end
                MODE_COMMENT, MODE_DROP: begin
                    n_mode = r_mode;
                end
                default: begin
                    // Between tokens; any unused code behaves the same.
                    if (is_space(i_in_char)) begin
                        n_mode = MODE_BETWEEN;
                    end else if (i_in_char == CH_DQUOTE) begin
                        n_seen             = 1'b1;
                        o_push.count       = 2'd1;
                        o_push.res0.kind   = KIND_BEGIN;
                        o_push.res0.quoted = 1'b1;
                        o_push.res0.last   = 1'b1;
                        n_mode             = MODE_QUOTE;
                    end else if (!r_seen && i_in_char == CH_HASH) begin
                        n_mode = MODE_COMMENT;
                    end else if (is_control(i_in_char)) begin
                        n_err  = ERR_CTRL_IN_WORD;
                        n_mode = MODE_DROP;
                    end else begin
                        n_seen           = 1'b1;
                        o_push.count     = 2'd2;
                        o_push.res0.kind = KIND_BEGIN;
                        o_push.res1      = mk_char(i_in_char);
                        n_mode           = MODE_WORD;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_BETWEEN;
            r_seen   <= 1'b0;
            r_nibble <= 4'd0;
            r_err    <= ERR_NONE;
        end else if (i_take) begin
            r_mode   <= n_mode;
            r_seen   <= n_seen;
            r_nibble <= n_nibble;
            r_err    <= n_err;
        end
    end

endmodule

[rtl/core/qlt_res_queue.sv]
// Small result queue: takes up to two results per cycle, hands out one.
module qlt_res_queue
    import qlt_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push_en,
    input  t_push                i_push,
    input  logic                 i_pop,
    output logic                 o_not_empty,
    output logic                 o_full_for_two,
    output logic [QLT_CNT_W-1:0] o_count,
    output t_result              o_head
);

    t_result              r_mem [QLT_QUEUE_DEPTH];
    logic [QLT_PTR_W-1:0] r_wr_ptr;
    logic [QLT_PTR_W-1:0] r_rd_ptr;
    logic [QLT_CNT_W-1:0] r_count;
    logic [QLT_CNT_W-1:0] n_count;
    logic [1:0]           w_push_cnt;
    logic [QLT_PTR_W-1:0] w_wr_next;

    assign w_push_cnt = i_push_en ? i_push.count : 2'd0;
    assign w_wr_next  = r_wr_ptr + QLT_PTR_W'(1);
    assign n_count    = r_count + QLT_CNT_W'(w_push_cnt) - QLT_CNT_W'(i_pop);

    assign o_not_empty    = r_count != '0;
    // Hold off new words unless two slots are free.
    assign o_full_for_two = r_count > QLT_CNT_W'(QLT_QUEUE_DEPTH - 2);
    assign o_count        = r_count;
    assign o_head         = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_push_cnt != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.res0;
        end
        if (w_push_cnt == 2'd2) begin
            r_mem[w_wr_next] <= i_push.res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + QLT_PTR_W'(w_push_cnt);
            r_rd_ptr <= r_rd_ptr + QLT_PTR_W'(i_pop);
            r_count  <= n_count;
        end
    end

endmodule

[rtl/core/quoted_line_tokenizer.sv]
// Top level: line tokenizer with quoted strings, escapes and error reporting.
// The results of an accepted word enter the result queue and are offered from its head.
// Throughput: one word per cycle unless o_stall; a word starting a bare token yields
//   two results, which drain one per cycle through a four-entry result queue while
//   i_stall is low. Input stall rises while fewer than two queue slots are free.
// Reset (synchronous, active low) returns the scanner to between tokens and
//   empties the queue.
module quoted_line_tokenizer
    import qlt_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_in_char,
    input  logic       i_line_end,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [1:0] o_kind,
    output logic [7:0] o_out_char,
    output logic       o_quoted,
    output logic [3:0] o_err_code,
    output logic       o_last
);

    logic                 w_take;
    logic                 w_pop;
    logic                 w_full_for_two;
    logic [QLT_CNT_W-1:0] w_count;
    t_push                w_push;
    t_result              w_head;

    assign o_stall = w_full_for_two;
    assign w_take  = i_valid && !w_full_for_two;
    assign w_pop   = o_valid && !i_stall;

    qlt_scan u_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_take     (w_take),
        .i_in_char  (i_in_char),
        .i_line_end (i_line_end),
        .o_push     (w_push)
    );

    qlt_res_queue u_queue (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push_en      (w_take),
        .i_push         (w_push),
        .i_pop          (w_pop),
        .o_not_empty    (o_valid),
        .o_full_for_two (w_full_for_two),
        .o_count        (w_count),
        .o_head         (w_head)
    );

    assign o_kind     = w_head.kind;
    assign o_out_char = w_head.out_char;
    assign o_quoted   = w_head.quoted;
    assign o_err_code = w_head.err_code;
    assign o_last     = w_head.last;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_count <= QLT_CNT_W'(QLT_QUEUE_DEPTH))
        else $error("result queue overflow");

    a_take_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |-> w_count <= QLT_CNT_W'(QLT_QUEUE_DEPTH - 2))
        else $error("word taken without room for two results");

    a_pair_is_begin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && w_push.count == 2'd2) |->
            (w_push.res0.kind == KIND_BEGIN && !w_push.res0.last && w_push.res1.last))
        else $error("two results must be token begin then character");

    a_line_end_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && i_line_end) |->
            (w_push.count == 2'd1 &&
             (w_push.res0.kind == KIND_OK || w_push.res0.kind == KIND_ERROR)))
        else $error("line end must give one status result");

    a_err_code_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind == KIND_ERROR) |-> o_err_code != ERR_NONE)
        else $error("line error result without error code");

endmodule
